/* sv/vmhd_pkg.sv */
// Shared types and constants for the varint message header deframer.
// No dependencies; used by the core, the output stage, the top level and the checker.
package vmhd_pkg;

  localparam logic [2:0] MAX_VARINT_BYTES = 3'd5;
  localparam logic [31:0] MASK_RESET = 32'd112;
  localparam logic [23:0] MAX_SIZE_RESET = 24'd1048576;

  typedef enum logic [1:0] {
    SEL_TYPE    = 2'd0,
    SEL_TICK    = 2'd1,
    SEL_SIZE    = 2'd2,
    SEL_PAYLOAD = 2'd3
  } sel_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_VARINT_LONG = 2'd1,
    ERR_TOO_BIG     = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    PHASE_RUNNING  = 2'd0,
    PHASE_END_SEEN = 2'd1,
    PHASE_FINAL    = 2'd2
  } phase_t;

  typedef enum logic {
    CFG_COMPRESSED_MASK  = 1'b0,
    CFG_MAX_PAYLOAD_SIZE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] msg_type;
    logic [31:0] tick;
    logic [31:0] size;
    logic        comp;
    phase_t      phase;
    logic [7:0]  data;
    logic        last;
    err_t        err;
  } result_t;

endpackage

/* sv/vmhd_in_stage.sv */
// Input register of the deframer: holds one byte transaction until the core consumes it.
// Depends on nothing beyond the ports.
module vmhd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_skip_message,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_skip
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       skip_r;

  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      skip_r <= in_skip_message;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;
  assign held_skip  = skip_r;

endmodule

/* sv/vmhd_core.sv */
// Deframer state and per-byte step logic: varint assembly, header build, payload pass.
// Uses vmhd_pkg for the field select, result and code types.
module vmhd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          data_byte,
  input  logic                skip,
  input  logic [31:0]         compressed_mask,
  input  logic [23:0]         max_payload_size,
  output logic                has_result,
  output vmhd_pkg::result_t   result
);

  vmhd_pkg::sel_t   sel_r, sel_nxt;
  logic [2:0]       count_r, count_nxt;
  logic [31:0]      accum_r, accum_nxt;
  logic [31:0]      type_r, type_nxt;
  logic [31:0]      tick_r, tick_nxt;
  logic [31:0]      remain_r, remain_nxt;
  logic             skip_r, skip_nxt;
  vmhd_pkg::phase_t phase_r, phase_nxt;
  logic             halted_r, halted_nxt;

  logic [5:0]       shamt;
  logic [31:0]      acc_new;
  logic             more;
  logic             overlong;
  logic [31:0]      remain_dec;
  logic             comp;
  logic [31:0]      clean;
  vmhd_pkg::phase_t phase_hdr;
  logic             too_big;

  // 7 * count as shift distance; groups beyond bit 31 fall away
  assign shamt      = ({3'b000, count_r} << 3) - {3'b000, count_r};
  assign acc_new    = accum_r | ({25'd0, data_byte[6:0]} << shamt);
  assign more       = data_byte[7];
  assign overlong   = count_r >= vmhd_pkg::MAX_VARINT_BYTES;
  assign remain_dec = remain_r - {31'd0, (remain_r != 32'd0)};
  assign comp       = (type_r & compressed_mask) != 32'd0;
  assign clean      = type_r & ~compressed_mask;
  assign too_big    = !skip && (acc_new > {8'd0, max_payload_size});

  always_comb begin
    phase_hdr = phase_r;
    if (phase_r == vmhd_pkg::PHASE_END_SEEN) phase_hdr = vmhd_pkg::PHASE_FINAL;
    if (clean == 32'd0) phase_hdr = vmhd_pkg::PHASE_END_SEEN;
  end

  // next state
  always_comb begin
    sel_nxt    = sel_r;
    count_nxt  = count_r;
    accum_nxt  = accum_r;
    type_nxt   = type_r;
    tick_nxt   = tick_r;
    remain_nxt = remain_r;
    skip_nxt   = skip_r;
    phase_nxt  = phase_r;
    halted_nxt = halted_r;
    if (!halted_r) begin
      if (sel_r == vmhd_pkg::SEL_PAYLOAD) begin
        remain_nxt = remain_dec;
        if (remain_dec == 32'd0) sel_nxt = vmhd_pkg::SEL_TYPE;
      end else if (overlong) begin
        halted_nxt = 1'b1;
      end else if (more) begin
        accum_nxt = acc_new;
        count_nxt = count_r + 3'd1;
      end else begin
        accum_nxt = 32'd0;
        count_nxt = 3'd0;
        unique case (sel_r)
          vmhd_pkg::SEL_TYPE: begin
            type_nxt = acc_new;
            sel_nxt  = vmhd_pkg::SEL_TICK;
          end
          vmhd_pkg::SEL_TICK: begin
            tick_nxt = acc_new;
            sel_nxt  = vmhd_pkg::SEL_SIZE;
          end
          default: begin
            phase_nxt = phase_hdr;
            if (too_big) begin
              halted_nxt = 1'b1;
            end else begin
              skip_nxt   = skip;
              remain_nxt = acc_new;
              sel_nxt    = (acc_new == 32'd0) ? vmhd_pkg::SEL_TYPE : vmhd_pkg::SEL_PAYLOAD;
            end
          end
        endcase
      end
    end
  end

  // result of this byte
  always_comb begin
    has_result   = 1'b0;
    result       = '0;
    result.phase = phase_r;
    if (!halted_r) begin
      if (sel_r == vmhd_pkg::SEL_PAYLOAD) begin
        has_result  = !skip_r;
        result.kind = vmhd_pkg::KIND_PAYLOAD;
        result.data = data_byte;
        result.last = remain_dec == 32'd0;
      end else if (overlong) begin
        has_result  = 1'b1;
        result.kind = vmhd_pkg::KIND_ERROR;
        result.err  = vmhd_pkg::ERR_VARINT_LONG;
      end else if (!more && sel_r == vmhd_pkg::SEL_SIZE) begin
        has_result   = 1'b1;
        result.phase = phase_hdr;
        if (too_big) begin
          result.kind = vmhd_pkg::KIND_ERROR;
          result.err  = vmhd_pkg::ERR_TOO_BIG;
        end else begin
          result.kind = vmhd_pkg::KIND_HEADER;
          result.last = skip || (acc_new == 32'd0);
          if (!skip) begin
            result.msg_type = clean;
            result.tick     = tick_r;
            result.size     = acc_new;
            result.comp     = comp;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r    <= vmhd_pkg::SEL_TYPE;
      count_r  <= 3'd0;
      accum_r  <= 32'd0;
      type_r   <= 32'd0;
      tick_r   <= 32'd0;
      remain_r <= 32'd0;
      skip_r   <= 1'b0;
      phase_r  <= vmhd_pkg::PHASE_RUNNING;
      halted_r <= 1'b0;
    end else if (step_en) begin
      sel_r    <= sel_nxt;
      count_r  <= count_nxt;
      accum_r  <= accum_nxt;
      type_r   <= type_nxt;
      tick_r   <= tick_nxt;
      remain_r <= remain_nxt;
      skip_r   <= skip_nxt;
      phase_r  <= phase_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

/* sv/vmhd_out_stage.sv */
// Result register of the deframer: holds one result transaction until the sink takes it.
// Uses vmhd_pkg::result_t.
module vmhd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  vmhd_pkg::result_t load_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              free,
  output vmhd_pkg::result_t data
);

  logic              valid_r;
  vmhd_pkg::result_t data_r;

  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign data      = data_r;

endmodule

/* sv/varint_message_header_deframer.sv */
// A byte accepted into the input register is stepped once the result register is free or
// the byte has no result; that step loads its result, if any, into the result register.
// Throughput: one byte per cycle unless a result waits on a full result register.
// Reset (rst_n low, synchronous): parse state, sticky error and both valid flags cleared,
// configuration back to mask 0x70 and size limit 1048576.
module varint_message_header_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_skip_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_message_type,
  output logic [31:0] out_message_tick,
  output logic [31:0] out_payload_size,
  output logic        out_is_compressed,
  output logic [1:0]  out_stream_phase,
  output logic [7:0]  out_payload_data,
  output logic        out_last_of_message,
  output logic [1:0]  out_error_code,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata
);

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              held_skip;
  logic              advance;
  logic              has_result;
  logic              out_free;
  vmhd_pkg::result_t step_res;
  vmhd_pkg::result_t out_res;
  logic [31:0]       compressed_mask_r;
  logic [23:0]       max_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compressed_mask_r <= vmhd_pkg::MASK_RESET;
      max_size_r        <= vmhd_pkg::MAX_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (vmhd_pkg::cfg_idx_t'(cfg_addr))
        vmhd_pkg::CFG_COMPRESSED_MASK:  compressed_mask_r <= cfg_wdata;
        vmhd_pkg::CFG_MAX_PAYLOAD_SIZE: max_size_r        <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // a byte with no result never waits on the sink
  assign advance = held_valid && (!has_result || out_free);

  vmhd_in_stage u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_skip_message (in_skip_message),
    .advance         (advance),
    .held_valid      (held_valid),
    .held_byte       (held_byte),
    .held_skip       (held_skip)
  );

  vmhd_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (advance),
    .data_byte        (held_byte),
    .skip             (held_skip),
    .compressed_mask  (compressed_mask_r),
    .max_payload_size (max_size_r),
    .has_result       (has_result),
    .result           (step_res)
  );

  vmhd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && has_result),
    .load_data (step_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .data      (out_res)
  );

  assign out_result_kind     = out_res.kind;
  assign out_message_type    = out_res.msg_type;
  assign out_message_tick    = out_res.tick;
  assign out_payload_size    = out_res.size;
  assign out_is_compressed   = out_res.comp;
  assign out_stream_phase    = out_res.phase;
  assign out_payload_data    = out_res.data;
  assign out_last_of_message = out_res.last;
  assign out_error_code      = out_res.err;

endmodule

/* sv/vmhd_checker.sv */
// Port-level checks for the deframer, bound to the top level.
// Uses vmhd_pkg codes; sees only the top-level ports.
module vmhd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_result_kind,
  input logic [31:0] out_message_type,
  input logic [31:0] out_message_tick,
  input logic [31:0] out_payload_size,
  input logic [7:0]  out_payload_data,
  input logic        out_last_of_message,
  input logic [1:0]  out_error_code
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind)
      && $stable(out_payload_data) && $stable(out_payload_size))
    else $error("result changed while stalled");

  // errors are sticky: nothing follows a taken error
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_result_kind == vmhd_pkg::KIND_ERROR |=> !out_valid)
    else $error("result after error");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == vmhd_pkg::KIND_ERROR
      |-> !out_last_of_message && out_error_code != vmhd_pkg::ERR_NONE)
    else $error("malformed error result");

  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == vmhd_pkg::KIND_PAYLOAD
      |-> out_message_type == 32'd0 && out_message_tick == 32'd0
        && out_payload_size == 32'd0 && out_error_code == vmhd_pkg::ERR_NONE)
    else $error("payload result carries header fields");

endmodule

bind varint_message_header_deframer vmhd_checker u_vmhd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_result_kind     (out_result_kind),
  .out_message_type    (out_message_type),
  .out_message_tick    (out_message_tick),
  .out_payload_size    (out_payload_size),
  .out_payload_data    (out_payload_data),
  .out_last_of_message (out_last_of_message),
  .out_error_code      (out_error_code)
);
